[rtl/core/mjd_pkg.sv]
package mjd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int COUNT_W   = 8;
    localparam int TIME_W    = 16;
    localparam int DRIVE_W   = 9;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_JAM_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_TIME  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TIME    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DRIVE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_DRIVE     = 3'd7;

    localparam logic [SAMPLE_W-1:0]       RST_JAM_THRESHOLD = 12'd3600;
    localparam logic [COUNT_W-1:0]        RST_DEBOUNCE      = 8'd5;
    localparam logic [TIME_W-1:0]         RST_BLANK_TIME    = 16'd500;
    localparam logic [TIME_W-1:0]         RST_STOP_TIME     = 16'd200;
    localparam logic [TIME_W-1:0]         RST_REVERSE_TIME  = 16'd500;
    localparam logic [TIME_W-1:0]         RST_PAUSE_TIME    = 16'd200;
    localparam logic signed [DRIVE_W-1:0] RST_REVERSE_DRIVE = -9'sd200;
    localparam logic signed [DRIVE_W-1:0] RST_RUN_DRIVE     = 9'sd225;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_STOP    = 2'd0,
        PH_REVERSE = 2'd1,
        PH_PAUSE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]       jam_threshold;
        logic [COUNT_W-1:0]        debounce_limit;
        logic [TIME_W-1:0]         blank_time;
        logic [TIME_W-1:0]         stop_time;
        logic [TIME_W-1:0]         reverse_time;
        logic [TIME_W-1:0]         pause_time;
        logic signed [DRIVE_W-1:0] reverse_drive;
        logic signed [DRIVE_W-1:0] run_drive;
    } cfg_t;

    typedef struct packed {
        logic                      jam_cleared;
        logic                      jam_detected;
        logic                      drive_update;
        logic signed [DRIVE_W-1:0] motor_drive;
        logic [1:0]                clear_phase;
        logic [1:0]                mode;
    } result_t;

endpackage

[rtl/core/motor_jam_detect_and_clear_top.sv]
// channel   | dir | payload (lowest bit up)                               | request
// s_*       | in  | tdata: current_sample[11:0]; tuser: opcode[1:0]       | s_tvalid & s_tready
// m_*       | out | tdata: mode, clear_phase, motor_drive, drive_update,  | m_tvalid & m_tready
//           |     |        jam_detected, jam_cleared                      |
// cfg_*     | in  | cfg_addr selects register, cfg_wdata holds value       | cfg_we
//
// one request per cycle sustained while m_tready is high
// input register, then state update and result register in one pass
// rst_n clears state to idle and the config registers to their defaults
// a stalled result holds in the output register; s_tready stays high while
// the input stage can move on
module motor_jam_detect_and_clear_top
    import mjd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // current_sample[11:0], zero pad
    input  logic [1:0]           s_tuser,   // opcode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // mode[1:0], clear_phase[3:2], motor_drive[12:4],
                                            // drive_update[13], jam_detected[14], jam_cleared[15]
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    result_t res;

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [OP_W-1:0]     s1_op_reg;
    logic                out_valid_reg;
    result_t             out_data_reg;
    logic                s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_sample_reg <= s_tdata[SAMPLE_W-1:0];
            s1_op_reg     <= s_tuser;
        end
        if (s1_advance)
        begin
            out_data_reg <= res;
        end
    end

    mjd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mjd_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (s1_advance),
        .sample (s1_sample_reg),
        .opcode (s1_op_reg),
        .cfg    (cfg),
        .res    (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/core/mjd_cfg.sv]
module mjd_cfg
    import mjd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.jam_threshold  <= RST_JAM_THRESHOLD;
            cfg_reg.debounce_limit <= RST_DEBOUNCE;
            cfg_reg.blank_time     <= RST_BLANK_TIME;
            cfg_reg.stop_time      <= RST_STOP_TIME;
            cfg_reg.reverse_time   <= RST_REVERSE_TIME;
            cfg_reg.pause_time     <= RST_PAUSE_TIME;
            cfg_reg.reverse_drive  <= RST_REVERSE_DRIVE;
            cfg_reg.run_drive      <= RST_RUN_DRIVE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_JAM_THRESHOLD: cfg_reg.jam_threshold  <= cfg_wdata[SAMPLE_W-1:0];
                REG_DEBOUNCE:      cfg_reg.debounce_limit <= cfg_wdata[COUNT_W-1:0];
                REG_BLANK_TIME:    cfg_reg.blank_time     <= cfg_wdata[TIME_W-1:0];
                REG_STOP_TIME:     cfg_reg.stop_time      <= cfg_wdata[TIME_W-1:0];
                REG_REVERSE_TIME:  cfg_reg.reverse_time   <= cfg_wdata[TIME_W-1:0];
                REG_PAUSE_TIME:    cfg_reg.pause_time     <= cfg_wdata[TIME_W-1:0];
                REG_REVERSE_DRIVE: cfg_reg.reverse_drive  <= signed'(cfg_wdata[DRIVE_W-1:0]);
                REG_RUN_DRIVE:     cfg_reg.run_drive      <= signed'(cfg_wdata[DRIVE_W-1:0]);
                default:           cfg_reg.run_drive      <= cfg_reg.run_drive;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/mjd_step.sv]
module mjd_step
    import mjd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [OP_W-1:0]     opcode,
    input  cfg_t                cfg,
    output result_t             res
);

    mode_t               mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [COUNT_W-1:0]  overload_reg, overload_next;

    logic [TIME_W-1:0]         elapsed_inc;
    logic [COUNT_W-1:0]        overload_inc;
    logic signed [DRIVE_W-1:0] drive;
    logic                      update, detected, cleared;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            phase_reg    <= PH_STOP;
            elapsed_reg  <= '0;
            overload_reg <= '0;
        end
        else if (en)
        begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            overload_reg <= overload_next;
        end
    end

    // saturating counters
    assign elapsed_inc  = (&elapsed_reg) ? elapsed_reg : elapsed_reg + 1'b1;
    assign overload_inc = (&overload_reg) ? overload_reg : overload_reg + 1'b1;

    always_comb
    begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        overload_next = overload_reg;
        drive         = '0;
        update        = 1'b0;
        detected      = 1'b0;
        cleared       = 1'b0;

        if (opcode == OP_START)
        begin
            mode_next     = MODE_RUN;
            phase_next    = PH_STOP;
            elapsed_next  = '0;
            overload_next = '0;
            drive         = cfg.run_drive;
            update        = 1'b1;
        end
        else if (opcode == OP_STOP)
        begin
            mode_next  = MODE_IDLE;
            phase_next = PH_STOP;
            update     = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_RUN:
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > cfg.blank_time)
                    begin
                        if (sample > cfg.jam_threshold)
                        begin
                            overload_next = overload_inc;
                            if (overload_inc > cfg.debounce_limit)
                            begin
                                mode_next    = MODE_CLEAR;
                                phase_next   = PH_STOP;
                                elapsed_next = '0;
                                detected     = 1'b1;
                            end
                        end
                        else
                        begin
                            overload_next = '0;
                        end
                    end
                end
                MODE_CLEAR:
                begin
                    elapsed_next = elapsed_inc;
                    update       = 1'b1;
                    unique case (phase_reg)
                        PH_STOP:
                        begin
                            if (elapsed_inc > cfg.stop_time)
                            begin
                                phase_next   = PH_REVERSE;
                                elapsed_next = '0;
                            end
                        end
                        PH_REVERSE:
                        begin
                            drive = cfg.reverse_drive;
                            if (elapsed_inc > cfg.reverse_time)
                            begin
                                phase_next   = PH_PAUSE;
                                elapsed_next = '0;
                            end
                        end
                        default:
                        begin
                            if (elapsed_inc > cfg.pause_time)
                            begin
                                mode_next     = MODE_RUN;
                                phase_next    = PH_STOP;
                                elapsed_next  = '0;
                                overload_next = '0;
                                drive         = cfg.run_drive;
                                cleared       = 1'b1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res.mode         = mode_next;
        res.clear_phase  = (mode_next == MODE_CLEAR) ? phase_next : PH_STOP;
        res.motor_drive  = drive;
        res.drive_update = update;
        res.jam_detected = detected;
        res.jam_cleared  = cleared;
    end

endmodule
